>>> hw/rtl/npcs_pkg.sv
// Shared types and constants for the nearest palette color search block.
package npcs_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int LIMIT_W     = $clog2(MAX_ENTRIES + 1);

   localparam int INDEX_W = 10;
   localparam int COLOR_W = 24;
   localparam int CHAN_W  = 8;
   localparam int SQ_W    = 2 * CHAN_W;
   localparam int WSQ_W   = SQ_W + CHAN_W;
   localparam int DIST_W  = 26;
   localparam int COUNT_W = 11;
   localparam int CSR_W   = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_RED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_GREEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_BLUE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT  = 2'd3;

   typedef struct packed {
      logic               mode;
      logic [INDEX_W-1:0] entry_index;
      logic [COLOR_W-1:0] entry_color;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
   } npcs_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] best_index;
      logic [COLOR_W-1:0] best_color;
      logic [DIST_W-1:0]  best_distance;
      logic               found;
   } npcs_rsp_type;

endpackage

>>> hw/rtl/nearest_palette_color_search.sv
// Nearest palette color search: top level with scan pipeline and palette RAM.
// Load: written to the palette RAM at the accepting edge, busy stays low, no result.
// Query over N = min(entry_count, MAX_ENTRIES) > 0 entries: busy while the N entries are read
// and pass the square, weight and sum stages; the strobe rises as busy drops. One palette RAM
// read per cycle. Query with N = 0: busy stays low and the result strobe comes in the next cycle.
// Reset clears weights to 1, entry_count to 0, busy and the valid flags; the palette is not cleared.
module nearest_palette_color_search (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  npcs_pkg::npcs_req_type       req_data,
   output logic                         rsp_valid,
   output npcs_pkg::npcs_rsp_type       rsp_data,
   input  logic                         csr_we,
   input  logic [npcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [npcs_pkg::CSR_W-1:0]   csr_wdata
);
   import npcs_pkg::*;

   // Configuration registers
   logic [CHAN_W-1:0]  weight_red_ff, weight_red_in;
   logic [CHAN_W-1:0]  weight_green_ff, weight_green_in;
   logic [CHAN_W-1:0]  weight_blue_ff, weight_blue_in;
   logic [COUNT_W-1:0] entry_count_ff, entry_count_in;

   // Scan control
   logic               busy_ff, busy_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [LIMIT_W-1:0] addr_ff, addr_in;
   logic [CHAN_W-1:0]  query_r_ff, query_r_in;
   logic [CHAN_W-1:0]  query_g_ff, query_g_in;
   logic [CHAN_W-1:0]  query_b_ff, query_b_in;

   // Pipeline: read issue (p), square (a), weight (b), sum (c)
   logic               p_valid_ff, p_valid_in;
   logic               p_last_ff, p_last_in;
   logic [ADDR_W-1:0]  p_idx_ff, p_idx_in;
   logic               a_valid_ff, a_valid_in;
   logic               a_last_ff, a_last_in;
   logic [ADDR_W-1:0]  a_idx_ff, a_idx_in;
   logic [COLOR_W-1:0] a_color_ff, a_color_in;
   logic [SQ_W-1:0]    a_sq_r_ff, a_sq_r_in;
   logic [SQ_W-1:0]    a_sq_g_ff, a_sq_g_in;
   logic [SQ_W-1:0]    a_sq_b_ff, a_sq_b_in;
   logic               b_valid_ff, b_valid_in;
   logic               b_last_ff, b_last_in;
   logic [ADDR_W-1:0]  b_idx_ff, b_idx_in;
   logic [COLOR_W-1:0] b_color_ff, b_color_in;
   logic [WSQ_W-1:0]   b_w_r_ff, b_w_r_in;
   logic [WSQ_W-1:0]   b_w_g_ff, b_w_g_in;
   logic [WSQ_W-1:0]   b_w_b_ff, b_w_b_in;
   logic               c_valid_ff, c_valid_in;
   logic               c_last_ff, c_last_in;
   logic [ADDR_W-1:0]  c_idx_ff, c_idx_in;
   logic [COLOR_W-1:0] c_color_ff, c_color_in;
   logic [DIST_W-1:0]  c_dist_ff, c_dist_in;

   // Running best
   logic               have_ff, have_in;
   logic [ADDR_W-1:0]  best_idx_ff, best_idx_in;
   logic [COLOR_W-1:0] best_color_ff, best_color_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   npcs_rsp_type       rsp_data_ff, rsp_data_in;

   // Memory side
   logic               accept;
   logic               load_we;
   logic               rd_en;
   logic [COLOR_W-1:0] rd_data;
   logic [LIMIT_W-1:0] count_limit;
   logic [CHAN_W-1:0]  diff_r, diff_g, diff_b;
   logic               take;

   assign accept  = start && !busy_ff;
   assign load_we = accept && (req_data.mode == MODE_LOAD)
                    && (32'(req_data.entry_index) < MAX_ENTRIES);
   assign rd_en   = busy_ff && (addr_ff < limit_ff);

   // Clamp the programmed count to the palette depth.
   always_comb begin
      if (32'(entry_count_ff) > MAX_ENTRIES) begin
         count_limit = LIMIT_W'(MAX_ENTRIES);
      end else begin
         count_limit = LIMIT_W'(entry_count_ff);
      end
   end

   npcs_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (MAX_ENTRIES)
   ) u_palette (
      .clock (clock),
      .we    (load_we),
      .waddr (ADDR_W'(req_data.entry_index)),
      .wdata (req_data.entry_color),
      .re    (rd_en),
      .raddr (addr_ff[ADDR_W-1:0]),
      .rdata (rd_data)
   );

   // Absolute channel differences against the held query color.
   always_comb begin
      if (query_r_ff > rd_data[23:16]) diff_r = query_r_ff - rd_data[23:16];
      else                              diff_r = rd_data[23:16] - query_r_ff;
      if (query_g_ff > rd_data[15:8])   diff_g = query_g_ff - rd_data[15:8];
      else                              diff_g = rd_data[15:8] - query_g_ff;
      if (query_b_ff > rd_data[7:0])    diff_b = query_b_ff - rd_data[7:0];
      else                              diff_b = rd_data[7:0] - query_b_ff;
   end

   // Pipeline datapath: squares in stage a, weights in stage b, the sum in stage c.
   assign p_valid_in = rd_en;
   assign p_last_in  = rd_en && (addr_ff + LIMIT_W'(1) == limit_ff);
   assign p_idx_in   = addr_ff[ADDR_W-1:0];

   assign a_valid_in = p_valid_ff;
   assign a_last_in  = p_last_ff;
   assign a_idx_in   = p_idx_ff;
   assign a_color_in = rd_data;
   assign a_sq_r_in  = SQ_W'(diff_r) * SQ_W'(diff_r);
   assign a_sq_g_in  = SQ_W'(diff_g) * SQ_W'(diff_g);
   assign a_sq_b_in  = SQ_W'(diff_b) * SQ_W'(diff_b);

   assign b_valid_in = a_valid_ff;
   assign b_last_in  = a_last_ff;
   assign b_idx_in   = a_idx_ff;
   assign b_color_in = a_color_ff;
   assign b_w_r_in   = WSQ_W'(weight_red_ff) * WSQ_W'(a_sq_r_ff);
   assign b_w_g_in   = WSQ_W'(weight_green_ff) * WSQ_W'(a_sq_g_ff);
   assign b_w_b_in   = WSQ_W'(weight_blue_ff) * WSQ_W'(a_sq_b_ff);

   assign c_valid_in = b_valid_ff;
   assign c_last_in  = b_last_ff;
   assign c_idx_in   = b_idx_ff;
   assign c_color_in = b_color_ff;
   assign c_dist_in  = DIST_W'(b_w_r_ff) + DIST_W'(b_w_g_ff) + DIST_W'(b_w_b_ff);

   // A later entry wins only on a strictly smaller distance; ties keep the earlier one.
   assign take = c_valid_ff && (!have_ff || (c_dist_ff < best_dist_ff));

   always_comb begin
      weight_red_in   = weight_red_ff;
      weight_green_in = weight_green_ff;
      weight_blue_in  = weight_blue_ff;
      entry_count_in  = entry_count_ff;
      busy_in         = busy_ff;
      limit_in        = limit_ff;
      addr_in         = addr_ff;
      query_r_in      = query_r_ff;
      query_g_in      = query_g_ff;
      query_b_in      = query_b_ff;
      have_in         = have_ff;
      best_idx_in     = best_idx_ff;
      best_color_in   = best_color_ff;
      best_dist_in    = best_dist_ff;
      rsp_valid_in    = 1'b0;
      rsp_data_in     = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_WEIGHT_RED:   weight_red_in   = csr_wdata[CHAN_W-1:0];
            CSR_WEIGHT_GREEN: weight_green_in = csr_wdata[CHAN_W-1:0];
            CSR_WEIGHT_BLUE:  weight_blue_in  = csr_wdata[CHAN_W-1:0];
            CSR_ENTRY_COUNT:  entry_count_in  = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end

      // Advance the read address while entries remain.
      if (rd_en) begin
         addr_in = addr_ff + LIMIT_W'(1);
      end

      if (take) begin
         have_in       = 1'b1;
         best_idx_in   = c_idx_ff;
         best_color_in = c_color_ff;
         best_dist_in  = c_dist_ff;
      end

      // Last entry leaves the compare: emit the result and drop busy.
      if (c_valid_ff && c_last_ff) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.best_index    = INDEX_W'(take ? c_idx_ff : best_idx_ff);
         rsp_data_in.best_color    = take ? c_color_ff : best_color_ff;
         rsp_data_in.best_distance = take ? c_dist_ff : best_dist_ff;
         rsp_data_in.found         = 1'b1;
         busy_in                   = 1'b0;
      end

      if (accept && (req_data.mode == MODE_QUERY)) begin
         query_r_in    = req_data.red;
         query_g_in    = req_data.green;
         query_b_in    = req_data.blue;
         limit_in      = count_limit;
         addr_in       = '0;
         have_in       = 1'b0;
         best_dist_in  = DIST_MAX;
         if (count_limit == '0) begin
            // Empty search: answer at once with the saturated distance.
            rsp_valid_in              = 1'b1;
            rsp_data_in.best_index    = '0;
            rsp_data_in.best_color    = '0;
            rsp_data_in.best_distance = DIST_MAX;
            rsp_data_in.found         = 1'b0;
         end else begin
            busy_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_red_ff   <= CHAN_W'(1);
         weight_green_ff <= CHAN_W'(1);
         weight_blue_ff  <= CHAN_W'(1);
         entry_count_ff  <= '0;
         busy_ff         <= 1'b0;
         p_valid_ff      <= 1'b0;
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         c_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         have_ff         <= 1'b0;
      end else begin
         weight_red_ff   <= weight_red_in;
         weight_green_ff <= weight_green_in;
         weight_blue_ff  <= weight_blue_in;
         entry_count_ff  <= entry_count_in;
         busy_ff         <= busy_in;
         p_valid_ff      <= p_valid_in;
         a_valid_ff      <= a_valid_in;
         b_valid_ff      <= b_valid_in;
         c_valid_ff      <= c_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         have_ff         <= have_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      limit_ff      <= limit_in;
      addr_ff       <= addr_in;
      query_r_ff    <= query_r_in;
      query_g_ff    <= query_g_in;
      query_b_ff    <= query_b_in;
      p_last_ff     <= p_last_in;
      p_idx_ff      <= p_idx_in;
      a_last_ff     <= a_last_in;
      a_idx_ff      <= a_idx_in;
      a_color_ff    <= a_color_in;
      a_sq_r_ff     <= a_sq_r_in;
      a_sq_g_ff     <= a_sq_g_in;
      a_sq_b_ff     <= a_sq_b_in;
      b_last_ff     <= b_last_in;
      b_idx_ff      <= b_idx_in;
      b_color_ff    <= b_color_in;
      b_w_r_ff      <= b_w_r_in;
      b_w_g_ff      <= b_w_g_in;
      b_w_b_ff      <= b_w_b_in;
      c_last_ff     <= c_last_in;
      c_idx_ff      <= c_idx_in;
      c_color_ff    <= c_color_in;
      c_dist_ff     <= c_dist_in;
      best_idx_ff   <= best_idx_in;
      best_color_ff <= best_color_in;
      best_dist_ff  <= best_dist_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result follows either a scan that was running or a query transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy_ff) || $past(start && req_data.mode == MODE_QUERY))
      else $error("result strobe without a query");

   // A result without a searched entry carries the saturated distance.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |-> (rsp_data_ff.best_distance == DIST_MAX))
      else $error("empty search distance not saturated");

   // A scan only runs over a non-empty range.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (limit_ff != '0))
      else $error("scan with empty range");

   // Entries in flight belong to a running scan.
   assert property (@(posedge clock) disable iff (reset)
      (p_valid_ff || a_valid_ff || b_valid_ff || c_valid_ff) |-> busy_ff)
      else $error("pipeline active while idle");

endmodule

>>> hw/rtl/npcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module npcs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sim/tb_nearest_palette_color_search.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nearest palette color search block.
module tb_nearest_palette_color_search;
   import npcs_pkg::*;

   // Run limits and pacing
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 20;
   // Low palette slots loaded before any scan goes past slot 7
   localparam int FILL_SLOTS    = 256;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic                 busy;
   npcs_req_type         req_data  = '0;
   logic                 rsp_valid;
   npcs_rsp_type         rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Items waiting for the driver, and nearest-color answers waiting for the block
   npcs_req_type pending_items[$];
   npcs_rsp_type expected_results[$];

   // Palette as the block holds it (updated on accepted loads) and as the
   // stimulus plans it (updated when a load is queued, used to aim queries)
   logic [COLOR_W-1:0] palette_model   [MAX_ENTRIES];
   logic [COLOR_W-1:0] planned_palette [MAX_ENTRIES];

   // Register shadows
   int unsigned weight_red_model   = 1;
   int unsigned weight_green_model = 1;
   int unsigned weight_blue_model  = 1;
   int unsigned entry_count_model  = 0;

   int           items_outstanding = 0;
   int           sender_idle_pct   = 0;
   int           error_count       = 0;
   int           cycle_count       = 0;
   logic         req_taken         = 1'b0;
   npcs_rsp_type next_expected;

   nearest_palette_color_search u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Squared difference of two color channels
   function automatic int unsigned channel_sq(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
      int unsigned diff;
      diff = (a > b) ? (a - b) : (b - a);
      return diff * diff;
   endfunction

   // Scan the palette in order and keep the strictly closest entry; on a tie
   // the lower slot stays. An empty scan gives slot 0, color 0, saturated distance.
   function automatic npcs_rsp_type nearest_entry(input logic [CHAN_W-1:0] qr,
                                                  input logic [CHAN_W-1:0] qg,
                                                  input logic [CHAN_W-1:0] qb);
      npcs_rsp_type       best;
      int unsigned        span;
      int unsigned        entry_dist;
      int unsigned        best_dist;
      logic [COLOR_W-1:0] entry;
      best      = '0;
      best_dist = 0;
      best.best_distance = DIST_MAX;
      // counts above the palette depth clamp to the depth
      span = (entry_count_model > MAX_ENTRIES) ? MAX_ENTRIES : entry_count_model;
      for (int i = 0; i < span; i++) begin
         entry      = palette_model[i];
         entry_dist = weight_red_model   * channel_sq(qr, entry[23:16])
                    + weight_green_model * channel_sq(qg, entry[15:8])
                    + weight_blue_model  * channel_sq(qb, entry[7:0]);
         if (!best.found || entry_dist < best_dist) begin
            best.found         = 1'b1;
            best.best_index    = INDEX_W'(i);
            best.best_color    = entry;
            best.best_distance = DIST_W'(entry_dist);
            best_dist          = entry_dist;
         end
      end
      return best;
   endfunction

   // Queue a palette load; the query fields carry random filler
   function automatic void queue_load(input int unsigned slot, input logic [COLOR_W-1:0] color);
      npcs_req_type item;
      item             = '0;
      item.mode        = MODE_LOAD;
      item.entry_index = INDEX_W'(slot);
      item.entry_color = color;
      item.red         = CHAN_W'($urandom);
      item.green       = CHAN_W'($urandom);
      item.blue        = CHAN_W'($urandom);
      planned_palette[slot] = color;
      pending_items.push_back(item);
      items_outstanding++;
   endfunction

   // Queue a nearest-color query; the load fields carry random filler
   function automatic void queue_query(input logic [COLOR_W-1:0] rgb);
      npcs_req_type item;
      item             = '0;
      item.mode        = MODE_QUERY;
      item.entry_index = INDEX_W'($urandom);
      item.entry_color = COLOR_W'($urandom);
      item.red         = rgb[23:16];
      item.green       = rgb[15:8];
      item.blue        = rgb[7:0];
      pending_items.push_back(item);
      items_outstanding++;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
      error_count++;
   endtask

   // Register write: one cycle of write enable, taken at the next rising edge.
   // Only called while the block is idle, so the shadows can move right away.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      case (idx)
         CSR_WEIGHT_RED:   weight_red_model   = value & 32'hFF;
         CSR_WEIGHT_GREEN: weight_green_model = value & 32'hFF;
         CSR_WEIGHT_BLUE:  weight_blue_model  = value & 32'hFF;
         CSR_ENTRY_COUNT:  entry_count_model  = value & 32'h7FF;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_weights(input int unsigned wr, input int unsigned wg, input int unsigned wb);
      write_register(CSR_WEIGHT_RED, wr);
      write_register(CSR_WEIGHT_GREEN, wg);
      write_register(CSR_WEIGHT_BLUE, wb);
   endtask

   // Wait until every queued item is taken and every answer is back, then let
   // the block settle. Loads finish at the accepting edge, so a short pause covers them.
   task automatic drain();
      while (items_outstanding != 0 || expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Driver: change inputs on the falling edge. Hold start and the item until the
   // transfer happens, then either present the next item or drop start.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_data <= pending_items.pop_front();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: sample on the rising edge. Check any result against the oldest
   // answer, then apply an accepted transfer to the palette or predict its answer.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no query outstanding", 32'd0,
                               32'(rsp_data.best_index));
            end else begin
               next_expected = expected_results.pop_front();
               if (rsp_data.best_index !== next_expected.best_index)
                  report_mismatch("best_index", 32'(next_expected.best_index),
                                  32'(rsp_data.best_index));
               if (rsp_data.best_color !== next_expected.best_color)
                  report_mismatch("best_color", 32'(next_expected.best_color),
                                  32'(rsp_data.best_color));
               if (rsp_data.best_distance !== next_expected.best_distance)
                  report_mismatch("best_distance", 32'(next_expected.best_distance),
                                  32'(rsp_data.best_distance));
               if (rsp_data.found !== next_expected.found)
                  report_mismatch("found", 32'(next_expected.found), 32'(rsp_data.found));
            end
         end
         if (start && !busy) begin
            items_outstanding--;
            if (req_data.mode == MODE_LOAD)
               palette_model[req_data.entry_index] = req_data.entry_color;
            else
               expected_results.push_back(nearest_entry(req_data.red, req_data.green,
                                                        req_data.blue));
         end
      end
   end

   // Watchdog: a hung handshake or a missing result ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int unsigned        window;
      int unsigned        count_value;
      int unsigned        slot;
      int unsigned        pick;
      logic [COLOR_W-1:0] color;
      int                 idle_choice [3];

      idle_choice = '{0, 83, 18};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- Directed part ---
      // Empty search straight out of reset (count 0), at both color extremes,
      // then seed slots 0..7; slot 5 repeats slot 2 to set up a tie.
      sender_idle_pct = 0;
      queue_query(24'h000000);
      queue_query(24'hFFFFFF);
      queue_load(0, 24'h000000);
      queue_load(1, 24'hFFFFFF);
      queue_load(2, 24'hFF0000);
      queue_load(3, 24'h00FF00);
      queue_load(4, 24'h0000FF);
      queue_load(5, 24'hFF0000);
      queue_load(6, 24'h808080);
      queue_load(7, 24'h7F7F7F);
      drain();

      // Unit weights over eight slots: exact hits, the tie on red, mid grays
      write_register(CSR_ENTRY_COUNT, 8);
      queue_query(24'h000000);
      queue_query(24'hFFFFFF);
      queue_query(24'hFF0000);
      queue_query(24'hC80A0A);
      queue_query(24'h808080);
      queue_query(24'h7F7F7F);
      drain();

      // Zero red weight: red and black collapse to the same distance
      set_weights(0, 255, 255);
      queue_query(24'h000000);
      queue_query(24'hFF0000);
      queue_query(24'h00FFFF);
      drain();

      // Full weights, one slot: largest possible distance
      set_weights(255, 255, 255);
      write_register(CSR_ENTRY_COUNT, 1);
      queue_query(24'hFFFFFF);
      drain();

      // Back to an empty search with nonunit weights
      write_register(CSR_ENTRY_COUNT, 0);
      queue_query(24'h123456);
      drain();

      // --- Fill the low slots so every count used below reads written slots only ---
      set_weights($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      for (int i = 0; i < FILL_SLOTS; i++) queue_load(i, COLOR_W'($urandom));
      drain();

      // Deepest scan over the loaded slots, including a hit on the last one
      write_register(CSR_ENTRY_COUNT, FILL_SLOTS);
      queue_query(COLOR_W'($urandom));
      queue_query(planned_palette[FILL_SLOTS-1]);
      drain();

      // --- Random phases ---
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         sender_idle_pct = idle_choice[p % 3];

         // weights: mostly random, sometimes at an extreme
         for (int w = 0; w < 3; w++) begin
            pick = $urandom_range(0, 9);
            write_register(CSR_IDX_W'(w),
                           (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255));
         end

         // count: mostly small scans, now and then empty or deep
         pick = $urandom_range(0, 19);
         if (pick == 0)
            count_value = 0;
         else if (pick == 1)
            count_value = FILL_SLOTS;
         else if (pick == 2)
            count_value = $urandom_range(100, FILL_SLOTS - 1);
         else
            count_value = $urandom_range(1, 32);
         write_register(CSR_ENTRY_COUNT, count_value);

         // slots the scan covers; loads mostly land there so queries see them
         if (count_value == 0)
            window = 32;
         else
            window = count_value;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) < 4) begin
               slot = ($urandom_range(0, 3) != 0) ? $urandom_range(0, window - 1)
                                                  : $urandom_range(0, MAX_ENTRIES - 1);
               pick = $urandom_range(0, 3);
               if (pick == 0)
                  color = planned_palette[$urandom_range(0, window - 1)];  // duplicate: tie
               else if (pick == 1)
                  color = planned_palette[$urandom_range(0, window - 1)] ^ COLOR_W'($urandom_range(0, 7));
               else
                  color = COLOR_W'($urandom);
               queue_load(slot, color);
            end else begin
               pick = $urandom_range(0, 3);
               if (pick == 0)
                  color = planned_palette[$urandom_range(0, window - 1)];  // zero distance
               else if (pick == 1)
                  color = planned_palette[$urandom_range(0, window - 1)] ^ COLOR_W'($urandom_range(0, 255));
               else if (pick == 2)
                  color = {$urandom_range(0, 1) ? 8'hFF : 8'h00,
                           $urandom_range(0, 1) ? 8'hFF : 8'h00,
                           $urandom_range(0, 1) ? 8'hFF : 8'h00};
               else
                  color = COLOR_W'($urandom);
               queue_query(color);
            end
         end
         drain();
      end

      // everything answered; keep clocking the idle block so that it can still misbehave
      repeat (2 * SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/npcs_pkg.sv
hw/rtl/npcs_ram.sv
hw/rtl/nearest_palette_color_search.sv
sim/tb_nearest_palette_color_search.sv
